/* sv/mad_pkg.sv */
// ============================================================================
// mad_pkg - shared types and constants for the modulated allpass diffuser
// Holds the datapath operation codes, register reset values and the sine table.
// ============================================================================
package mad_pkg;

    // Datapath operation codes, issued by the controller once per cycle
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_CLEAR  = 4'd1;
    localparam logic [3:0] OP_ACCEPT = 4'd2;
    localparam logic [3:0] OP_SIN    = 4'd3;
    localparam logic [3:0] OP_OFF    = 4'd4;
    localparam logic [3:0] OP_POS    = 4'd5;
    localparam logic [3:0] OP_WRAP   = 4'd6;
    localparam logic [3:0] OP_RDA    = 4'd7;
    localparam logic [3:0] OP_RDB    = 4'd8;
    localparam logic [3:0] OP_MB     = 4'd9;
    localparam logic [3:0] OP_TAP    = 4'd10;
    localparam logic [3:0] OP_Y      = 4'd11;
    localparam logic [3:0] OP_W      = 4'd12;

    // Configuration register indexes
    localparam logic [2:0] REG_DELAY_LENGTH = 3'd0;
    localparam logic [2:0] REG_FEEDBACK     = 3'd1;
    localparam logic [2:0] REG_LFO_INC      = 3'd2;
    localparam logic [2:0] REG_LFO_START    = 3'd3;
    localparam logic [2:0] REG_MOD_SCALE    = 3'd4;

    localparam int CFG_W = 24;

    // Register reset values
    localparam logic [12:0] RST_DELAY_LENGTH = 13'd601;
    localparam logic [14:0] RST_FEEDBACK     = 15'd11469;
    localparam logic [19:0] RST_LFO_INC      = 20'd380;
    localparam logic [23:0] RST_LFO_START    = 24'd0;
    localparam logic [15:0] RST_MOD_SCALE    = 16'd8192;

    localparam logic [6:0] MOD_DEPTH = 7'd49;

    typedef struct packed {
        logic [3:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic wrap_ok;
        logic out_free;
    } t_dp_status;

    typedef logic [14:0] t_sine_tab [0:256];

    // Quarter-wave sine in Q1.15, 7th-order series with floored products
    function automatic t_sine_tab f_build_sine();
        t_sine_tab tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned q30_one;
        longint unsigned q30_hpi;
        q30_one = 64'd1073741824;
        q30_hpi = 64'd1686629713;
        for (int k = 0; k <= 256; k++) begin
            x  = (longint'(k) * q30_hpi) >> 8;
            x2 = (x * x) >> 30;
            t  = q30_one - x2 / 42;
            t  = q30_one - ((x2 * t) >> 30) / 20;
            t  = q30_one - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            s  = (s + 64'd16384) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            tab[k] = s[14:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_build_sine();

endpackage

/* sv/mad_ctrl.sv */
// ============================================================================
// mad_ctrl - sequencer for the modulated allpass diffuser
// Steps the datapath through line clearing and the per-sample operations.
// ============================================================================
module mad_ctrl
    import mad_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_dp_status i_status,
    output logic       o_ready,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SIN  = 4'd2;
    localparam logic [3:0] S_OFF  = 4'd3;
    localparam logic [3:0] S_POS  = 4'd4;
    localparam logic [3:0] S_WRAP = 4'd5;
    localparam logic [3:0] S_RDA  = 4'd6;
    localparam logic [3:0] S_RDB  = 4'd7;
    localparam logic [3:0] S_MB   = 4'd8;
    localparam logic [3:0] S_TAP  = 4'd9;
    localparam logic [3:0] S_Y    = 4'd10;
    localparam logic [3:0] S_W    = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and command
    always_comb begin
        n_state = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLEAR;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_state = S_SIN;
                end
            end
            S_SIN: begin
                o_cmd.op = OP_SIN;
                n_state = S_OFF;
            end
            S_OFF: begin
                o_cmd.op = OP_OFF;
                n_state = S_POS;
            end
            S_POS: begin
                o_cmd.op = OP_POS;
                n_state = S_WRAP;
            end
            S_WRAP: begin
                o_cmd.op = OP_WRAP;
                if (i_status.wrap_ok) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                o_cmd.op = OP_RDA;
                n_state = S_RDB;
            end
            S_RDB: begin
                o_cmd.op = OP_RDB;
                n_state = S_MB;
            end
            S_MB: begin
                o_cmd.op = OP_MB;
                n_state = S_TAP;
            end
            S_TAP: begin
                o_cmd.op = OP_TAP;
                n_state = S_Y;
            end
            S_Y: begin
                o_cmd.op = OP_Y;
                n_state = S_W;
            end
            S_W: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.op = OP_W;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

/* sv/mad_dp.sv */
// ============================================================================
// mad_dp - datapath of the modulated allpass diffuser
// Config registers, LFO, delay memory, shared multiplier and output register.
// ============================================================================
module mad_dp
    import mad_pkg::*;
#(
    parameter int LINE_DEPTH   = 8192,
    parameter int SAMPLE_BITS  = 24,
    parameter int MOD_HEADROOM = 64
)
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_status,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    localparam int SB      = SAMPLE_BITS;
    localparam int ADDR_W  = $clog2(LINE_DEPTH);
    localparam int BASE_W  = ADDR_W + 1;
    localparam int CMP_W   = (BASE_W > 13) ? BASE_W : 13;
    localparam int POS_W   = ADDR_W + 10;
    localparam int MA_W    = SB + 8;
    localparam int MB_W    = 18;
    localparam int P_W     = MA_W + MB_W;
    localparam int SAT_W   = SB + 2;
    localparam logic [CMP_W-1:0] MAX_BASE = CMP_W'(LINE_DEPTH - MOD_HEADROOM);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LINE_DEPTH - 1);
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((2 ** (SB - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    // configuration
    logic [12:0] r_delay_length;
    logic [14:0] r_fb;
    logic [19:0] r_inc;
    logic [15:0] r_scale;

    // per-sample state
    logic [23:0]             r_phase;
    logic [ADDR_W-1:0]       r_wp;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic signed [SB-1:0]    r_x;
    logic signed [15:0]      r_sine;
    logic signed [P_W-1:0]   r_prod;
    logic signed [P_W-1:0]   r_acc;
    logic signed [POS_W-1:0] r_pos;
    logic signed [SB-1:0]    r_rd;
    logic signed [SB-1:0]    r_tap;
    logic signed [SB-1:0]    r_y;
    logic                    r_out_valid;
    logic signed [SB-1:0]    r_out;

    logic signed [SB-1:0] mem [0:LINE_DEPTH-1];

    logic [CMP_W-1:0]        w_dl_ext;
    logic [BASE_W-1:0]       w_base;
    logic [BASE_W-1:0]       w_n;
    logic signed [POS_W-1:0] w_span;
    logic signed [POS_W-1:0] w_rel;
    logic signed [POS_W-1:0] w_rel_wrap;
    logic signed [POS_W-1:0] w_off;
    logic [ADDR_W-1:0]       w_i0;
    logic [ADDR_W-1:0]       w_i1;
    logic [BASE_W-1:0]       w_i0_inc;
    logic [7:0]              w_frac;
    logic [9:0]              w_idx;
    logic [8:0]              w_k;
    logic [14:0]             w_ent;
    logic signed [15:0]      w_sine;
    logic [ADDR_W-1:0]       w_wp_eff;
    logic [BASE_W-1:0]       w_wp_inc;
    logic signed [MA_W-1:0]  w_ma;
    logic signed [MB_W-1:0]  w_mb;
    logic signed [P_W-1:0]   w_prod;
    logic signed [P_W-1:0]   w_tap_sum;
    logic signed [SAT_W-1:0] w_y_raw;
    logic signed [SAT_W-1:0] w_w_raw;
    logic signed [SB-1:0]    w_w;
    logic                    w_out_take;

    function automatic logic signed [SB-1:0] f_sat(input logic signed [SAT_W-1:0] v);
        logic signed [SB-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[SB-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[SB-1:0];
        end else begin
            res = v[SB-1:0];
        end
        return res;
    endfunction

    // clamp base delay and derive line length
    always_comb begin
        w_dl_ext = CMP_W'(r_delay_length);
        if (w_dl_ext == '0) begin
            w_base = BASE_W'(1);
        end else if (w_dl_ext > MAX_BASE) begin
            w_base = MAX_BASE[BASE_W-1:0];
        end else begin
            w_base = w_dl_ext[BASE_W-1:0];
        end
        w_n    = w_base + BASE_W'(MOD_HEADROOM);
        w_span = $signed(POS_W'(w_n)) <<< 8;
    end

    // sine lookup from the current phase
    always_comb begin
        w_idx = r_phase[23:14];
        w_k   = w_idx[8] ? (9'd256 - {1'b0, w_idx[7:0]}) : {1'b0, w_idx[7:0]};
        w_ent = SINE_TAB[w_k];
        w_sine = w_idx[9] ? -$signed({1'b0, w_ent}) : $signed({1'b0, w_ent});
    end

    // read position helpers
    always_comb begin
        w_wp_eff = (BASE_W'(r_wp) >= w_n) ? '0 : r_wp;
        w_wp_inc = BASE_W'(r_wp) + BASE_W'(1);
        w_rel = ($signed(POS_W'(r_wp)) - $signed(POS_W'(w_base))) <<< 8;
        w_rel_wrap = (w_rel < 0) ? (w_rel + w_span) : w_rel;
        w_off = POS_W'(r_prod >>> 21);
        w_i0 = r_pos[ADDR_W+7:8];
        w_frac = r_pos[7:0];
        w_i0_inc = BASE_W'(w_i0) + BASE_W'(1);
        w_i1 = (w_i0_inc == w_n) ? '0 : w_i0_inc[ADDR_W-1:0];
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_SIN: begin
                w_ma = MA_W'(r_sine);
                w_mb = $signed(MB_W'(MOD_DEPTH));
            end
            OP_OFF: begin
                w_ma = $signed(r_prod[MA_W-1:0]);
                w_mb = $signed({2'b00, r_scale});
            end
            OP_RDB: begin
                w_ma = MA_W'(r_rd);
                w_mb = $signed(MB_W'(9'd256 - {1'b0, w_frac}));
            end
            OP_MB: begin
                w_ma = MA_W'(r_rd);
                w_mb = $signed(MB_W'(w_frac));
            end
            OP_TAP: begin
                w_ma = MA_W'(r_x);
                w_mb = $signed({3'b000, r_fb});
            end
            OP_Y: begin
                w_ma = MA_W'(r_tap);
                w_mb = $signed({3'b000, r_fb});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = P_W'(w_ma) * P_W'(w_mb);
    end

    // allpass arithmetic
    always_comb begin
        w_tap_sum = (r_acc + r_prod) >>> 8;
        w_y_raw = SAT_W'(r_tap) - SAT_W'(r_prod >>> 15);
        w_w_raw = SAT_W'(r_x) + SAT_W'(r_prod >>> 15);
        w_w = f_sat(w_w_raw);
    end

    assign w_out_take = r_out_valid && !i_stall;

    // configuration and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length <= RST_DELAY_LENGTH;
            r_fb           <= RST_FEEDBACK;
            r_inc          <= RST_LFO_INC;
            r_scale        <= RST_MOD_SCALE;
            r_phase        <= RST_LFO_START;
            r_wp           <= '0;
            r_clr_addr     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DELAY_LENGTH: r_delay_length <= i_cfg_data[12:0];
                    REG_FEEDBACK:     r_fb <= i_cfg_data[14:0];
                    REG_LFO_INC:      r_inc <= i_cfg_data[19:0];
                    REG_MOD_SCALE:    r_scale <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            // load the phase on a start write, otherwise advance per transaction
            if (i_cfg_we && (i_cfg_index == REG_LFO_START)) begin
                r_phase <= i_cfg_data[23:0];
            end else if (i_cmd.op == OP_ACCEPT) begin
                r_phase <= r_phase + 24'(r_inc);
            end
            if (i_cmd.op == OP_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.op == OP_ACCEPT) begin
                r_wp <= w_wp_eff;
            end else if (i_cmd.op == OP_W) begin
                r_wp <= (w_wp_inc == w_n) ? '0 : w_wp_inc[ADDR_W-1:0];
            end
            // drop on delivery, set on completion
            if (i_cmd.op == OP_W) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_x    <= i_sample_in;
                r_sine <= w_sine;
            end
            OP_SIN: r_prod <= w_prod;
            OP_OFF: r_prod <= w_prod;
            OP_POS: r_pos <= w_rel_wrap + w_off;
            OP_WRAP: begin
                if (r_pos < 0) begin
                    r_pos <= r_pos + w_span;
                end else if (r_pos >= w_span) begin
                    r_pos <= r_pos - w_span;
                end
            end
            OP_RDB: r_prod <= w_prod;
            OP_MB: begin
                r_acc  <= r_prod;
                r_prod <= w_prod;
            end
            OP_TAP: begin
                r_tap  <= w_tap_sum[SB-1:0];
                r_prod <= w_prod;
            end
            OP_Y: begin
                r_y    <= f_sat(w_y_raw);
                r_prod <= w_prod;
            end
            OP_W: r_out <= r_y;
            default: begin
            end
        endcase
    end

    // delay line memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CLEAR) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.op == OP_W) begin
            mem[r_wp] <= w_w;
        end
        if (i_cmd.op == OP_RDA) begin
            r_rd <= mem[w_i0];
        end else if (i_cmd.op == OP_RDB) begin
            r_rd <= mem[w_i1];
        end
    end

    assign o_status.clear_done = (r_clr_addr == LAST_ADDR);
    assign o_status.wrap_ok    = (r_pos >= 0) && (r_pos < w_span);
    assign o_status.out_free   = !r_out_valid || !i_stall;
    assign o_valid             = r_out_valid;
    assign o_sample_out        = r_out;

endmodule

/* sv/modulated_allpass_diffuser_core.sv */
// Sequence: an accepted sample steps through SIN, OFF, POS, WRAP, RDA, RDB, MB, TAP,
//   Y and W; WRAP repeats until the tap position lies in the line, and W sets output valid.
// Flow: a new sample is accepted only when idle, after W, which waits on output stall;
//   the shared multiplier and the single-port delay memory are sequenced by the controller.
// Reset: synchronous, active low; afterwards the controller clears all LINE_DEPTH
//   addresses of the delay line (8192 by default) before the first transaction.
// ============================================================================
// modulated_allpass_diffuser_core - modulated allpass diffuser top level
// Allpass section on an LFO-modulated, interpolated circular delay line.
// ============================================================================
module modulated_allpass_diffuser_core
    import mad_pkg::*;
#(
    parameter int LINE_DEPTH   = 8192,
    parameter int SAMPLE_BITS  = 24,
    parameter int MOD_HEADROOM = 64
)
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_ready;

    // sequencer
    mad_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_ready  (w_ready),
        .o_cmd    (w_cmd)
    );

    // datapath
    mad_dp #(
        .LINE_DEPTH   (LINE_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MOD_HEADROOM (MOD_HEADROOM)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_sample_in  (i_sample_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out)
    );

    assign o_stall = !w_ready;

endmodule
